// ===== sv/ppi_pkg.sv =====
// shared types and constants for the plane-plane intersection line unit
// no dependencies; used by every module of the block
package ppi_pkg;

  // fixed-point format of inputs and results
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  // magnitude width of cross product and offset vector terms
  localparam int MAG_W     = 64;
  // width of squared and triple products
  localparam int PROD_W    = 2 * MAG_W;
  // quotient bits produced by the divider, one per stage
  localparam int QBITS     = DATA_W;
  // numerator alignment for the divider
  localparam int DIV_SH    = QBITS - FRAC_BITS;
  // threshold alignment against the squared cross length
  localparam int THR_SH    = 4 * FRAC_BITS - 32;
  localparam int CMP_W     = PROD_W + 32;
  // cycles from an accepted request to its result strobe
  localparam int PIPE_DEPTH = 7 + QBITS;

  // configuration port
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 2'd0;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'd43;

  // one divider lane: partial remainder, quotient and pending numerator bits
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QBITS-1:0]  quo;
    logic [QBITS-1:0]  nbits;
  } div_lane_t;

  // direction result, already rescaled and saturated
  typedef struct packed {
    logic [2:0][DATA_W-1:0] dir;
    logic                   dclip;
  } dir_res_t;

  // per-request control traveling beside the divider lanes
  typedef struct packed {
    logic              meets;
    logic [2:0]        ovf;
    logic [2:0]        wsgn;
    logic [PROD_W-1:0] det;
    dir_res_t          dres;
  } side_t;

endpackage

// ===== sv/ppi_mul64.sv =====
// two-stage unsigned 64x64 multiplier built from four 32x32 partial products
// depends on ppi_pkg
module ppi_mul64 (
  input  logic                        clk,
  input  logic [ppi_pkg::MAG_W-1:0]   a,
  input  logic [ppi_pkg::MAG_W-1:0]   b,
  output logic [ppi_pkg::PROD_W-1:0]  p
);
  localparam int HW = ppi_pkg::MAG_W / 2;

  logic [ppi_pkg::MAG_W-1:0] pp_ll, pp_lh, pp_hl, pp_hh;

  // partial products
  always_ff @(posedge clk) begin
    pp_ll <= a[HW-1:0]  * b[HW-1:0];
    pp_lh <= a[HW-1:0]  * b[2*HW-1:HW];
    pp_hl <= a[2*HW-1:HW] * b[HW-1:0];
    pp_hh <= a[2*HW-1:HW] * b[2*HW-1:HW];
  end

  // sum of aligned partial products
  always_ff @(posedge clk) begin
    p <= ppi_pkg::PROD_W'(pp_ll)
       + (ppi_pkg::PROD_W'(pp_lh) << HW)
       + (ppi_pkg::PROD_W'(pp_hl) << HW)
       + (ppi_pkg::PROD_W'(pp_hh) << (2 * HW));
  end

endmodule

// ===== sv/ppi_div_step.sv =====
// one registered step of a restoring divider: one quotient bit per stage
// depends on ppi_pkg
module ppi_div_step (
  input  logic                       clk,
  input  logic [ppi_pkg::PROD_W-1:0] det,
  input  ppi_pkg::div_lane_t         lane_in,
  output ppi_pkg::div_lane_t         lane_out
);
  logic [ppi_pkg::PROD_W:0] trial;
  logic [ppi_pkg::PROD_W:0] diff;
  logic                     ge;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    trial = {lane_in.rem, lane_in.nbits[ppi_pkg::QBITS-1]};
    diff  = trial - {1'b0, det};
    ge    = (trial >= {1'b0, det});
  end

  always_ff @(posedge clk) begin
    lane_out.rem   <= ge ? diff[ppi_pkg::PROD_W-1:0] : trial[ppi_pkg::PROD_W-1:0];
    lane_out.quo   <= {lane_in.quo[ppi_pkg::QBITS-2:0], ge};
    lane_out.nbits <= {lane_in.nbits[ppi_pkg::QBITS-2:0], 1'b0};
  end

endmodule

// ===== sv/plane_plane_intersection_line_unit.sv =====
// top level of the plane-plane intersection line unit
// depends on ppi_pkg, ppi_mul64 and ppi_div_step
//
// Takes one plane pair per clock cycle and returns its intersection line.
// busy is always low: the block never refuses a request, and the result
// is shown for exactly one cycle with done high. The origin divider is a
// restoring divider with one stage per quotient bit (32 stages), in front
// of which sit six stages of products, cross terms, split 64x64
// multipliers and the threshold/overflow checks. The user must write
// parallel_threshold over the APB port at address 0 only while no request
// is in flight; the block itself does not enforce this.
module plane_plane_intersection_line_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_a_nx,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_a_ny,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_a_nz,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_a_dist,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_b_nx,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_b_ny,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_b_nz,
  input  logic signed [ppi_pkg::DATA_W-1:0]  plane_b_dist,
  output logic                               done,
  output logic                               meets,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_dir_x,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_dir_y,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_dir_z,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_org_x,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_org_y,
  output logic signed [ppi_pkg::DATA_W-1:0]  line_org_z,
  output logic                               clipped,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppi_pkg::ADDR_W-1:0]         paddr,
  input  logic [ppi_pkg::DATA_W-1:0]         pwdata,
  output logic [ppi_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  localparam int DW = ppi_pkg::DATA_W;
  localparam int MW = ppi_pkg::MAG_W;
  localparam int PW = ppi_pkg::PROD_W;
  localparam int QB = ppi_pkg::QBITS;

  // rescale a magnitude by the fraction bits, round half away, saturate
  function automatic logic [DW:0] rescale_sat(input logic [MW-1:0] mag, input logic neg);
    logic [MW:0]   m;
    logic [DW-1:0] val;
    logic          clip;
    m = ({1'b0, mag} + ((MW+1)'(1) << (ppi_pkg::FRAC_BITS - 1))) >> ppi_pkg::FRAC_BITS;
    clip = 1'b0;
    if (!neg) begin
      if (m > (MW+1)'(33'h0_7FFF_FFFF)) begin
        clip = 1'b1;
        val  = 32'h7FFF_FFFF;
      end else begin
        val = m[DW-1:0];
      end
    end else begin
      if (m > (MW+1)'(33'h0_8000_0000)) begin
        clip = 1'b1;
        val  = 32'h8000_0000;
      end else begin
        val = -m[DW-1:0];
      end
    end
    return {clip, val};
  endfunction

  // configuration register
  logic [DW-1:0] thr;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ppi_pkg::ADDR_THRESHOLD);
  assign prdata = (paddr == ppi_pkg::ADDR_THRESHOLD) ? thr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ppi_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      thr <= pwdata;
    end
  end

  // stage 1: signed 32x32 products for cross product and offset vector
  logic                 v1;
  logic signed [63:0]   pc [6];
  logic signed [63:0]   pv [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pc[0] <= plane_a_ny * plane_b_nz;
    pc[1] <= plane_a_nz * plane_b_ny;
    pc[2] <= plane_a_nz * plane_b_nx;
    pc[3] <= plane_a_nx * plane_b_nz;
    pc[4] <= plane_a_nx * plane_b_ny;
    pc[5] <= plane_a_ny * plane_b_nx;
    pv[0] <= plane_a_dist * plane_b_nx;
    pv[1] <= plane_b_dist * plane_a_nx;
    pv[2] <= plane_a_dist * plane_b_ny;
    pv[3] <= plane_b_dist * plane_a_ny;
    pv[4] <= plane_a_dist * plane_b_nz;
    pv[5] <= plane_b_dist * plane_a_nz;
  end

  // stage 2: cross product and offset vector, as sign and magnitude
  logic             v2;
  logic [MW-1:0]    cmag [3];
  logic [MW-1:0]    vmag [3];
  logic [2:0]       csgn, vsgn;
  logic signed [MW:0] cdiff [3];
  logic signed [MW:0] vdiff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cdiff[i] = (MW+1)'(pc[2*i]) - (MW+1)'(pc[2*i+1]);
      vdiff[i] = (MW+1)'(pv[2*i]) - (MW+1)'(pv[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      csgn[i] <= cdiff[i][MW];
      vsgn[i] <= vdiff[i][MW];
      cmag[i] <= cdiff[i][MW] ? MW'(-cdiff[i]) : cdiff[i][MW-1:0];
      vmag[i] <= vdiff[i][MW] ? MW'(-vdiff[i]) : vdiff[i][MW-1:0];
    end
  end

  // stages 3 and 4: wide products; direction result computed alongside
  logic                 v3, v4;
  logic [5:0]           s3, s4;
  ppi_pkg::dir_res_t    dres_next, dres3, dres4, dres5;
  logic [PW-1:0]        sq [3];
  logic [PW-1:0]        tp [6];
  logic [DW:0]          rs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = rescale_sat(cmag[i], csgn[i]);
      dres_next.dir[i] = rs[i][DW-1:0];
    end
    dres_next.dclip = rs[0][DW] | rs[1][DW] | rs[2][DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= v2;
      v4 <= v3;
    end
  end

  // term order: v1c2, v2c1, v2c0, v0c2, v0c1, v1c0
  always_ff @(posedge clk) begin
    s3    <= {vsgn[1] ^ csgn[0], vsgn[0] ^ csgn[1], vsgn[0] ^ csgn[2],
              vsgn[2] ^ csgn[0], vsgn[2] ^ csgn[1], vsgn[1] ^ csgn[2]};
    s4    <= s3;
    dres3 <= dres_next;
    dres4 <= dres3;
  end

  ppi_mul64 u_sq0 (.clk(clk), .a(cmag[0]), .b(cmag[0]), .p(sq[0]));
  ppi_mul64 u_sq1 (.clk(clk), .a(cmag[1]), .b(cmag[1]), .p(sq[1]));
  ppi_mul64 u_sq2 (.clk(clk), .a(cmag[2]), .b(cmag[2]), .p(sq[2]));
  ppi_mul64 u_tp0 (.clk(clk), .a(vmag[1]), .b(cmag[2]), .p(tp[0]));
  ppi_mul64 u_tp1 (.clk(clk), .a(vmag[2]), .b(cmag[1]), .p(tp[1]));
  ppi_mul64 u_tp2 (.clk(clk), .a(vmag[2]), .b(cmag[0]), .p(tp[2]));
  ppi_mul64 u_tp3 (.clk(clk), .a(vmag[0]), .b(cmag[2]), .p(tp[3]));
  ppi_mul64 u_tp4 (.clk(clk), .a(vmag[0]), .b(cmag[1]), .p(tp[4]));
  ppi_mul64 u_tp5 (.clk(clk), .a(vmag[1]), .b(cmag[0]), .p(tp[5]));

  // stage 5: squared cross length and numerator vector (offset x cross)
  logic              v5;
  logic [PW-1:0]     det5;
  logic [PW-1:0]     wmag [3];
  logic [2:0]        wsgn;
  logic signed [PW+1:0] sp [6];
  logic signed [PW+1:0] wv [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sp[i] = s4[i] ? -$signed({2'b00, tp[i]}) : $signed({2'b00, tp[i]});
    end
    for (int i = 0; i < 3; i++) begin
      wv[i] = sp[2*i] - sp[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    det5  <= sq[0] + sq[1] + sq[2];
    dres5 <= dres4;
    for (int i = 0; i < 3; i++) begin
      wsgn[i] <= wv[i][PW+1];
      wmag[i] <= wv[i][PW+1] ? PW'(-wv[i]) : wv[i][PW-1:0];
    end
  end

  // stage 6: threshold test, quotient overflow test, divider load
  logic                 vld  [QB+1];
  ppi_pkg::side_t       side [QB+1];
  ppi_pkg::div_lane_t   lane0 [3];
  ppi_pkg::div_lane_t   lane_s [QB][3];
  ppi_pkg::side_t       side_next;

  always_comb begin
    side_next.det   = det5;
    side_next.dres  = dres5;
    side_next.wsgn  = wsgn;
    side_next.meets = (det5 != '0) &&
                      ({32'b0, det5} >= (ppi_pkg::CMP_W'(thr) << ppi_pkg::THR_SH));
    for (int i = 0; i < 3; i++) begin
      side_next.ovf[i] = {ppi_pkg::DIV_SH'(0), wmag[i]} >= {det5, ppi_pkg::DIV_SH'(0)};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lane0[i].rem   <= wmag[i] >> ppi_pkg::DIV_SH;
      lane0[i].quo   <= '0;
      lane0[i].nbits <= QB'(wmag[i] << ppi_pkg::FRAC_BITS);
    end
  end

  // control chain beside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= v5;
      for (int k = 0; k < QB; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= side_next;
    for (int k = 0; k < QB; k++) begin
      side[k+1] <= side[k];
    end
  end

  // divider stages, one quotient bit each, three lanes
  for (genvar k = 0; k < QB; k++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      if (k == 0) begin : g_first
        ppi_div_step u_step (.clk(clk), .det(side[k].det), .lane_in(lane0[j]),
                             .lane_out(lane_s[k][j]));
      end else begin : g_rest
        ppi_div_step u_step (.clk(clk), .det(side[k].det), .lane_in(lane_s[k-1][j]),
                             .lane_out(lane_s[k][j]));
      end
    end
  end

  // final stage: round, restore sign, saturate
  logic [DW-1:0] org [3];
  logic [2:0]    oclip;
  logic [DW:0]   qr [3];
  logic          up [3];
  ppi_pkg::side_t sf;

  always_comb begin
    sf = side[QB];
    for (int i = 0; i < 3; i++) begin
      up[i] = {lane_s[QB-1][i].rem, 1'b0} >= {1'b0, sf.det};
      qr[i] = {1'b0, lane_s[QB-1][i].quo} + (DW+1)'(up[i]);
      if (sf.wsgn[i]) begin
        oclip[i] = sf.ovf[i] || (qr[i] > 33'h0_8000_0000);
        org[i]   = oclip[i] ? 32'h8000_0000 : -qr[i][DW-1:0];
      end else begin
        oclip[i] = sf.ovf[i] || (qr[i] > 33'h0_7FFF_FFFF);
        org[i]   = oclip[i] ? 32'h7FFF_FFFF : qr[i][DW-1:0];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    meets      <= sf.meets;
    line_dir_x <= sf.meets ? sf.dres.dir[0] : '0;
    line_dir_y <= sf.meets ? sf.dres.dir[1] : '0;
    line_dir_z <= sf.meets ? sf.dres.dir[2] : '0;
    line_org_x <= sf.meets ? org[0] : '0;
    line_org_y <= sf.meets ? org[1] : '0;
    line_org_z <= sf.meets ? org[2] : '0;
    clipped    <= sf.meets && (sf.dres.dclip || (oclip != 3'b000));
  end

  // every accepted request comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(ppi_pkg::PIPE_DEPTH) done)
    else $error("request did not produce a result at the expected cycle");

  // a parallel pair reports an all-zero line
  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    done && !meets |-> (clipped == 1'b0) && (line_dir_x == '0) && (line_dir_y == '0) &&
                       (line_dir_z == '0) && (line_org_x == '0) && (line_org_y == '0) &&
                       (line_org_z == '0))
    else $error("parallel result carries nonzero fields");

  // a threshold write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> thr == $past(pwdata))
    else $error("threshold write lost");

endmodule

// ===== dv/plane_plane_intersection_line_unit_test.sv =====
`timescale 1ns / 1ps
// testbench for plane_plane_intersection_line_unit: directed table, then random plane pairs
// depends on ppi_pkg and the unit's RTL; self-checking against an exact-integer line predictor
module plane_plane_intersection_line_unit_test;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic signed [31:0] an[3];
    logic signed [31:0] ad;
    logic signed [31:0] bn[3];
    logic signed [31:0] bd;
  } plane_pair_t;

  typedef struct {
    logic               meets;
    logic signed [31:0] dir[3];
    logic signed [31:0] org[3];
    logic               clipped;
  } line_t;

  typedef struct {
    plane_pair_t p;
    bit          typed;
    line_t       line;
  } table_row_t;

  localparam int LATENCY = ppi_pkg::PIPE_DEPTH + 6;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, meets, clipped, pready;
  logic signed [ppi_pkg::DATA_W-1:0] plane_a_nx = 0, plane_a_ny = 0, plane_a_nz = 0;
  logic signed [ppi_pkg::DATA_W-1:0] plane_a_dist = 0;
  logic signed [ppi_pkg::DATA_W-1:0] plane_b_nx = 0, plane_b_ny = 0, plane_b_nz = 0;
  logic signed [ppi_pkg::DATA_W-1:0] plane_b_dist = 0;
  logic signed [ppi_pkg::DATA_W-1:0] line_dir_x, line_dir_y, line_dir_z;
  logic signed [ppi_pkg::DATA_W-1:0] line_org_x, line_org_y, line_org_z;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ppi_pkg::ADDR_W-1:0] paddr = ppi_pkg::ADDR_THRESHOLD;
  logic [ppi_pkg::DATA_W-1:0] pwdata = 0;
  logic [ppi_pkg::DATA_W-1:0] prdata;

  plane_plane_intersection_line_unit dut (.*);

  always #2 clk = ~clk;

  logic [31:0] threshold_shadow = ppi_pkg::THRESHOLD_RESET;
  line_t       lines_pending[$];
  bit          use_typed = 0;
  line_t       typed_line;
  int          mismatches = 0;
  int          requests = 0;
  int          lines_met = 0;
  int          lines_parallel = 0;
  int          lines_clipped = 0;

  // saturate to the signed 32-bit range and flag the clip
  function automatic logic signed [31:0] clamp32(big_t v, ref logic clip);
    if (v > big_t'(64'sd2147483647)) begin
      clip = 1;
      return 32'sh7fffffff;
    end
    if (v < -big_t'(64'sd2147483648)) begin
      clip = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic line_t intersect_planes(plane_pair_t p, logic [31:0] thr);
    line_t r;
    big_t a[3], b[3], c[3], v[3], w[3], da, db, det, m, q, rem;
    logic clip;
    clip = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = p.an[i];
      b[i] = p.bn[i];
    end
    da = p.ad;
    db = p.bd;
    r.meets = 0;
    r.clipped = 0;
    for (int i = 0; i < 3; i++) begin
      r.dir[i] = 0;
      r.org[i] = 0;
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    det = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    // det carries 64 fraction bits, threshold 32
    if (det == 0 || (det <<< 32) < (big_t'(thr) <<< 64)) return r;
    for (int i = 0; i < 3; i++) v[i] = da * b[i] - db * a[i];
    w[0] = v[1] * c[2] - v[2] * c[1];
    w[1] = v[2] * c[0] - v[0] * c[2];
    w[2] = v[0] * c[1] - v[1] * c[0];
    r.meets = 1;
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      m = (m + (big_t'(1) <<< (ppi_pkg::FRAC_BITS - 1))) >>> ppi_pkg::FRAC_BITS;
      r.dir[i] = clamp32(c[i] < 0 ? -m : m, clip);
      m = (w[i] < 0 ? -w[i] : w[i]) <<< ppi_pkg::FRAC_BITS;
      q = m / det;
      rem = m % det;
      if ((rem <<< 1) >= det) q = q + 1;
      r.org[i] = clamp32(w[i] < 0 ? -q : q, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  // request capture and result check, both on pre-edge values
  always @(posedge clk) begin
    line_t e;
    plane_pair_t p;
    if (!rst && start && !busy) begin
      p.an[0] = plane_a_nx; p.an[1] = plane_a_ny; p.an[2] = plane_a_nz; p.ad = plane_a_dist;
      p.bn[0] = plane_b_nx; p.bn[1] = plane_b_ny; p.bn[2] = plane_b_nz; p.bd = plane_b_dist;
      lines_pending.push_back(use_typed ? typed_line : intersect_planes(p, threshold_shadow));
      requests++;
    end
    if (!rst && done) begin
      if (lines_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result strobe at %0t", $time);
      end else begin
        e = lines_pending.pop_front();
        if (e.meets !== meets || e.clipped !== clipped ||
            e.dir[0] !== line_dir_x || e.dir[1] !== line_dir_y || e.dir[2] !== line_dir_z ||
            e.org[0] !== line_org_x || e.org[1] !== line_org_y || e.org[2] !== line_org_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $time);
            $display("  expected meets=%0d dir=%0d,%0d,%0d org=%0d,%0d,%0d clipped=%0d",
                     e.meets, e.dir[0], e.dir[1], e.dir[2],
                     e.org[0], e.org[1], e.org[2], e.clipped);
            $display("  actual   meets=%0d dir=%0d,%0d,%0d org=%0d,%0d,%0d clipped=%0d",
                     meets, line_dir_x, line_dir_y, line_dir_z,
                     line_org_x, line_org_y, line_org_z, clipped);
          end
        end
        if (e.meets) lines_met++; else lines_parallel++;
        if (e.clipped) lines_clipped++;
      end
    end
  end

  task automatic issue(plane_pair_t p, bit typed, line_t l);
    start <= 1;
    use_typed <= typed;
    typed_line <= l;
    plane_a_nx <= p.an[0]; plane_a_ny <= p.an[1]; plane_a_nz <= p.an[2]; plane_a_dist <= p.ad;
    plane_b_nx <= p.bn[0]; plane_b_ny <= p.bn[1]; plane_b_nz <= p.bn[2]; plane_b_dist <= p.bd;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (lines_pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // apb write then read back
  task automatic set_threshold(logic [31:0] value);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= ppi_pkg::ADDR_THRESHOLD; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    threshold_shadow = value;
    pwrite <= 0; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata !== value) begin
      mismatches++;
      if (mismatches <= 10) $display("threshold readback %h, expected %h", prdata, value);
    end
    psel <= 0; penable <= 0;
  endtask

  // random field: full range, up to two in magnitude, tiny, or up to 256 in magnitude
  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 262144)) - 131072;
      2: return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom_range(0, 33554432)) - 16777216;
    endcase
  endfunction

  function automatic plane_pair_t random_pair();
    plane_pair_t p;
    int mode;
    int kind;
    mode = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      p.an[i] = rand_coord(mode);
      p.bn[i] = rand_coord(mode);
    end
    p.ad = rand_coord($urandom_range(0, 3));
    p.bd = rand_coord($urandom_range(0, 3));
    // nearly parallel or exactly parallel normals, or one zeroed normal component
    if (kind == 0)
      for (int i = 0; i < 3; i++) p.bn[i] = p.an[i] + rand_coord(2);
    else if (kind == 1)
      for (int i = 0; i < 3; i++) p.bn[i] = -p.an[i];
    else if (kind == 2)
      p.an[$urandom_range(0, 2)] = 0;
    return p;
  endfunction

  function automatic plane_pair_t make_pair(int ax, int ay, int az, int ad,
                                            int bx, int by, int bz, int bd);
    plane_pair_t p;
    p.an[0] = ax; p.an[1] = ay; p.an[2] = az; p.ad = ad;
    p.bn[0] = bx; p.bn[1] = by; p.bn[2] = bz; p.bd = bd;
    return p;
  endfunction

  function automatic line_t make_line(bit m, int dx, int dy, int dz, int ox, int oy, int oz,
                                      bit cl);
    line_t l;
    l.meets = m; l.clipped = cl;
    l.dir[0] = dx; l.dir[1] = dy; l.dir[2] = dz;
    l.org[0] = ox; l.org[1] = oy; l.org[2] = oz;
    return l;
  endfunction

  localparam int ONE = 1 << ppi_pkg::FRAC_BITS;
  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;

  table_row_t directed[$];
  line_t none;

  initial begin
    logic [31:0] thresholds[4];
    int per_phase;
    none = make_line(0, 0, 0, 0, 0, 0, 0, 0);
    // x = 2 and y = 3 meet along z through (2, 3, 0)
    directed.push_back('{make_pair(ONE, 0, 0, 2*ONE, 0, ONE, 0, 3*ONE), 1,
                         make_line(1, 0, 0, ONE, 2*ONE, 3*ONE, 0, 0)});
    directed.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, none});
    directed.push_back('{make_pair(ONE, ONE, 0, ONE, ONE, ONE, 0, 5*ONE), 1, none});
    directed.push_back('{make_pair(ONE, 0, 0, 0, -ONE, 0, 0, ONE), 1, none});
    directed.push_back('{make_pair(0, 0, ONE, -ONE, ONE, 0, 0, ONE), 0, none});
    directed.push_back('{make_pair(MX, MX, MX, MX, MN, MN, MN, MN), 0, none});
    directed.push_back('{make_pair(MX, 0, 0, MX, 0, MX, 0, MN), 0, none});
    directed.push_back('{make_pair(MN, 0, MX, MN, 0, MN, MX, MX), 0, none});
    directed.push_back('{make_pair(MN, MN, 0, MX, MX, 0, MN, MN), 0, none});
    directed.push_back('{make_pair(1, 0, 0, MX, 0, 1, 0, MN), 0, none});
    directed.push_back('{make_pair(1, 0, 0, 0, 0, 1, 0, 0), 0, none});
    directed.push_back('{make_pair(ONE, 0, 0, 0, ONE, 1, 0, 0), 0, none});
    directed.push_back('{make_pair(-1, -1, -1, -1, 1, -2, 3, -4), 0, none});
    directed.push_back('{make_pair(ONE, 2*ONE, 3*ONE, MX, -3*ONE, ONE, ONE, MN), 0, none});

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows at reset threshold
    foreach (directed[i]) issue(directed[i].p, directed[i].typed, directed[i].line);
    drain();

    thresholds[0] = 32'd0;
    thresholds[1] = 32'hffffffff;
    thresholds[2] = $urandom;
    thresholds[3] = ppi_pkg::THRESHOLD_RESET;
    per_phase = 375;
    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(thresholds[ph]);
      for (int n = 0; n < per_phase; n++) begin
        issue(random_pair(), 0, none);
        // in phase 1, wait for the pipeline to empty once mid-phase
        if (ph == 1 && n == per_phase / 2) drain();
        idle_gap(!(ph == 3 && n > per_phase - 100));
      end
      drain();
    end

    $display("%0d plane pairs sent over 5 threshold settings", requests);
    $display("%0d lines met, %0d parallel, %0d with saturation",
             lines_met, lines_parallel, lines_clipped);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ppi_pkg.sv
sv/ppi_mul64.sv
sv/ppi_div_step.sv
sv/plane_plane_intersection_line_unit.sv
dv/plane_plane_intersection_line_unit_test.sv
